@@ hdl/sorted_priority_queue_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sorted priority queue core
// Hold the clock and reset context for the concurrent checks in one place.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Check an expression at every edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("sorted priority queue check failed");

// Check that a condition implies a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

@@ hdl/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Types and codes shared by the queue cells and the top level.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // One stored entry as seen by a neighbor cell.
  typedef struct packed {
    logic                    occ;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell; ins and rem are already qualified.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } op_t;

endpackage

@@ hdl/spq_cell.sv @@
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Hold one entry; on insert compare and shift right, on remove shift left.
// ---------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  op_t    op_i,
  input  entry_t left_i,
  input  logic   left_cond_i,
  input  entry_t right_i,
  output entry_t entry_o,
  output logic   cond_o
);

  logic                    occ_q, occ_d;
  logic signed [DataW-1:0] value_q, value_d;
  logic signed [DataW-1:0] priority_q, priority_d;

  // Insert point at or before this cell: empty, or stored priority not below new.
  assign cond_o = !occ_q || !(priority_q < op_i.prio);

  always_comb begin
    occ_d      = occ_q;
    value_d    = value_q;
    priority_d = priority_q;
    if (op_i.ins) begin
      if (left_cond_i) begin
        occ_d      = left_i.occ;
        value_d    = left_i.value;
        priority_d = left_i.prio;
      end else if (cond_o) begin
        occ_d      = 1'b1;
        value_d    = op_i.value;
        priority_d = op_i.prio;
      end
    end else if (op_i.rem) begin
      occ_d      = right_i.occ;
      value_d    = right_i.value;
      priority_d = right_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    priority_q <= priority_d;
  end

  assign entry_o = '{occ: occ_q, value: value_q, prio: priority_q};

endmodule

@@ hdl/sorted_priority_queue_core.sv @@
// ---------------------------------------------------------------------------
// Sorted priority queue core
// Bounded priority queue built as a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
// The queue holds up to CAPACITY entries in ascending priority order, front
// entry in cell 0. An insert item (tuser 0) places its entry before the first
// stored entry whose priority is greater than or equal to its own, so equal
// priorities leave in reverse order of arrival; a remove item (tuser 1) takes
// out the front entry and returns it. Every item yields exactly one result
// item whose tuser is the status: 0 done, 1 remove on empty, 2 insert on full.
// Data and priority of a result are zero except on a successful remove. Every
// cell compares its own priority with the new one in parallel and loads from
// its left or right neighbor in the same edge, so a new item is taken every
// cycle while the result register is free or is being drained. The result is
// registered and valid in the cycle after the item is accepted. After reset
// the queue is empty at once; no clearing pass is needed.
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] item_value, [63:32] item_priority
  input  logic [0:0]  s_axis_tuser_i,   // [0] kind
  // Result item stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] out_value, [63:32] out_priority
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  // Cell row wiring.
  entry_t [CAPACITY-1:0] entry;
  logic   [CAPACITY-1:0] cond;
  logic   [CAPACITY-1:0] occ_vec;
  op_t                   op;

  logic    in_accept;
  kind_e   kind;
  logic    full, empty;

  // Result register.
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic signed [DataW-1:0] out_value_q, out_value_d;
  logic signed [DataW-1:0] out_priority_q, out_priority_d;

  // Accept while the result slot is free or drains this cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign kind            = kind_e'(s_axis_tuser_i[0]);

  // Occupancy is a thermometer: last cell full means queue full.
  assign full  = occ_vec[CAPACITY-1];
  assign empty = !occ_vec[0];

  // Broadcast the qualified operation to every cell.
  assign op.ins   = in_accept && (kind == KIND_INSERT) && !full;
  assign op.rem   = in_accept && (kind == KIND_REMOVE) && !empty;
  assign op.value = $signed(s_axis_tdata_i[31:0]);
  assign op.prio  = $signed(s_axis_tdata_i[63:32]);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_cond;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_cond  = 1'b0;
    end else begin : g_body
      assign left_entry = entry[i-1];
      assign left_cond  = cond[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .left_i      (left_entry),
      .left_cond_i (left_cond),
      .right_i     (right_entry),
      .entry_o     (entry[i]),
      .cond_o      (cond[i])
    );

    assign occ_vec[i] = entry[i].occ;
  end

  // Build the result for the accepted item; hold it until taken.
  always_comb begin
    out_valid_d    = out_valid_q;
    out_status_d   = out_status_q;
    out_value_d    = out_value_q;
    out_priority_d = out_priority_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_accept) begin
      out_valid_d    = 1'b1;
      out_status_d   = STATUS_DONE;
      out_value_d    = '0;
      out_priority_d = '0;
      case (kind)
        KIND_INSERT: begin
          if (full) begin
            out_status_d = STATUS_FULL;
          end
        end
        KIND_REMOVE: begin
          if (empty) begin
            out_status_d = STATUS_EMPTY;
          end else begin
            out_value_d    = entry[0].value;
            out_priority_d = entry[0].prio;
          end
        end
        default: begin
          out_status_d = STATUS_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_DONE;
    end else begin
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q    <= out_value_d;
    out_priority_q <= out_priority_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_priority_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;

  // Events watched by the checks below.
  logic rem_on_empty, empty_reported;
  assign rem_on_empty   = in_accept && (kind == KIND_REMOVE) && empty;
  assign empty_reported = m_axis_tvalid_o && (m_axis_tuser_o == STATUS_EMPTY);

  // Occupied cells always form a contiguous run from the front.
  `SPQ_ASSERT_ALWAYS(a_occ_thermometer, (occ_vec & (occ_vec + CAPACITY'(1))) == '0)

  // A remove on an empty queue reports empty on the next cycle.
  `SPQ_ASSERT_NEXT(a_remove_empty, rem_on_empty, empty_reported)

  // A successful insert leaves the front cell occupied and reports done.
  `SPQ_ASSERT_NEXT(a_insert_fills, op.ins, occ_vec[0] && (m_axis_tuser_o == STATUS_DONE))

endmodule
